/* src/positional_list_engine_core_defines.svh */
// ----------------------------------------------------------------------------
// positional list engine - assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ple_pkg.sv */
// ----------------------------------------------------------------------------
// positional list engine - package
// request and error codes, beat layout and cell control type
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DEFAULT_LIST_DEPTH    = 16;
   localparam int DEFAULT_PAYLOAD_WIDTH = 32;

   // fixed field widths on the ports
   localparam int REQ_W      = 2;
   localparam int POS_W      = 5;
   localparam int PORT_PAY_W = 32;
   localparam int CNT_PORT_W = 5;
   localparam int ERR_W      = 2;

   // request kinds
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   // request beat layout
   localparam int REQ_POS_LSB = 0;
   localparam int REQ_PAY_LSB = REQ_POS_LSB + POS_W;
   localparam int REQ_USED_W  = REQ_PAY_LSB + PORT_PAY_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // response beat layout
   localparam int RSP_PAY_LSB   = 0;
   localparam int RSP_CNT_LSB   = RSP_PAY_LSB + PORT_PAY_W;
   localparam int RSP_FULL_BIT  = RSP_CNT_LSB + CNT_PORT_W;
   localparam int RSP_EMPTY_BIT = RSP_FULL_BIT + 1;
   localparam int RSP_ERR_LSB   = RSP_EMPTY_BIT + 1;
   localparam int RSP_USED_W    = RSP_ERR_LSB + ERR_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // shift command broadcast to every cell of the row
   typedef struct packed {
      logic             do_insert;
      logic             do_delete;
      logic [POS_W-1:0] position;
   } shift_ctrl_type;

endpackage

/* src/ple_cell.sv */
// ----------------------------------------------------------------------------
// positional list engine - list cell
// holds one entry, shifts from either neighbour or loads the new payload
// ----------------------------------------------------------------------------
module ple_cell
   import ple_pkg::*;
#(
   parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH,
   parameter int INDEX         = 0
) (
   input  logic                     clock,
   input  shift_ctrl_type           ctrl,
   input  logic [PAYLOAD_WIDTH-1:0] prev_data,
   input  logic [PAYLOAD_WIDTH-1:0] next_data,
   input  logic [PAYLOAD_WIDTH-1:0] load_data,
   output logic [PAYLOAD_WIDTH-1:0] data,
   output logic [PAYLOAD_WIDTH-1:0] rd_data
);

   localparam int IDX_BITS = $clog2(INDEX + 2);
   localparam int IW       = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;
   localparam logic [IW-1:0] IDX = IW'(INDEX);

   logic [PAYLOAD_WIDTH-1:0] data_ff;
   logic [PAYLOAD_WIDTH-1:0] data_in;
   logic [IW-1:0]            pos_ext;
   logic                     hit;
   logic                     above;

   assign pos_ext = IW'(ctrl.position);
   assign hit     = (pos_ext == IDX);
   assign above   = (IDX > pos_ext);

   always_comb begin
      data_in = data_ff;
      if (ctrl.do_insert) begin
         if (above) begin
            data_in = prev_data;
         end else if (hit) begin
            data_in = load_data;
         end
      end else if (ctrl.do_delete && (hit || above)) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = hit ? data_ff : '0;

endmodule

/* src/ple_decode.sv */
// ----------------------------------------------------------------------------
// positional list engine - request decode
// range and full checks, shift command and next entry count
// ----------------------------------------------------------------------------
module ple_decode
   import ple_pkg::*;
#(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
   parameter int CNT_W      = $clog2(DEFAULT_LIST_DEPTH + 1)
) (
   input  logic              accept,
   input  logic [REQ_W-1:0]  req_kind,
   input  logic [POS_W-1:0]  position,
   input  logic [CNT_W-1:0]  count,
   output shift_ctrl_type    ctrl,
   output logic              peek_hit,
   output logic [ERR_W-1:0]  err,
   output logic [CNT_W-1:0]  count_next
);

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             ins_ok;
   logic             del_ok;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count);

   always_comb begin
      ins_ok   = 1'b0;
      del_ok   = 1'b0;
      peek_hit = 1'b0;
      err      = ERR_OK;
      case (req_kind)
         REQ_INSERT: begin
            if (count == DEPTH_CNT) begin
               err = ERR_FULL;
            end else if (pos_ext > cnt_ext) begin
               err = ERR_RANGE;
            end else begin
               ins_ok = 1'b1;
            end
         end
         REQ_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               err = ERR_RANGE;
            end else begin
               del_ok = 1'b1;
            end
         end
         REQ_PEEK: begin
            if (pos_ext >= cnt_ext) begin
               err = ERR_RANGE;
            end else begin
               peek_hit = 1'b1;
            end
         end
         default: begin
            err = ERR_OK;
         end
      endcase
   end

   always_comb begin
      count_next = count;
      if (ins_ok) begin
         count_next = count + CNT_W'(1);
      end else if (del_ok) begin
         count_next = count - CNT_W'(1);
      end
   end

   assign ctrl.do_insert = accept && ins_ok;
   assign ctrl.do_delete = accept && del_ok;
   assign ctrl.position  = position;

endmodule

/* src/positional_list_engine_core.sv */
// ----------------------------------------------------------------------------
// positional list engine - top level
// ordered list with insert, delete and peek at a position
// ----------------------------------------------------------------------------
// The list lives in a row of LIST_DEPTH cells, one entry each; an insert
// moves every entry at or above the position up one cell and a delete
// moves every entry above it down one, all cells shifting together on the
// same clock edge, so a new beat is accepted each cycle that the response
// register is empty or being drained. The response register holds a
// finished result until the receiver takes it; while it waits the request
// side is held off, and the next request goes in on the same edge that the
// waiting result leaves. A result appears in the cycle after its request.
// Each response carries the peeked payload (zero unless a peek hit a live
// entry), the entry count after the request, full and empty flags and an
// error code; a flagged request leaves the list untouched. Entries hold no
// reset value, only the entry count and response valid flag are cleared,
// and no read ever reaches an entry at or above the count.
module positional_list_engine_core
   import ple_pkg::*;
#(
   parameter int LIST_DEPTH    = DEFAULT_LIST_DEPTH,
   parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [4:0] position, [36:5] item_payload, [39:37] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [REQ_W-1:0]       req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] read_payload, [36:32] entry_count, [37] is_full, [38] is_empty,
   // [40:39] error_code, [47:41] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   // handshake and entry count
   logic                     req_accept;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_tvalid_ff;
   logic                     rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_in;

   // decoded request
   shift_ctrl_type           ctrl;
   logic                     peek_hit;
   logic [ERR_W-1:0]         err;
   logic [CNT_W-1:0]         count_next;
   logic [POS_W-1:0]         req_position;
   logic [PAYLOAD_WIDTH-1:0] load_data;

   // cell row
   logic [PAYLOAD_WIDTH-1:0] cell_data [LIST_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] cell_rd   [LIST_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] rd_any;

   // a new beat goes in whenever the response register is empty or frees up this cycle
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign req_position = req_tdata[REQ_POS_LSB +: POS_W];
   // payload cut or zero-extended to the stored width
   assign load_data    = PAYLOAD_WIDTH'(req_tdata[REQ_PAY_LSB +: PORT_PAY_W]);

   ple_decode #(
      .LIST_DEPTH (LIST_DEPTH),
      .CNT_W      (CNT_W)
   ) u_decode (
      .accept     (req_accept),
      .req_kind   (req_tuser),
      .position   (req_position),
      .count      (count_ff),
      .ctrl       (ctrl),
      .peek_hit   (peek_hit),
      .err        (err),
      .count_next (count_next)
   );

   // row of cells, each wired to both neighbours; the end cells see themselves
   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [PAYLOAD_WIDTH-1:0] prev_data;
      logic [PAYLOAD_WIDTH-1:0] next_data;

      if (k == 0) begin : g_first
         assign prev_data = cell_data[k];
      end else begin : g_prev
         assign prev_data = cell_data[k-1];
      end

      if (k == LIST_DEPTH - 1) begin : g_last
         assign next_data = cell_data[k];
      end else begin : g_next
         assign next_data = cell_data[k+1];
      end

      ple_cell #(
         .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
         .INDEX         (k)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .prev_data (prev_data),
         .next_data (next_data),
         .load_data (load_data),
         .data      (cell_data[k]),
         .rd_data   (cell_rd[k])
      );
   end

   // only the addressed cell drives a non-zero read value
   always_comb begin
      rd_any = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         rd_any = rd_any | cell_rd[k];
      end
   end

   // response beat assembled from the state after this request
   always_comb begin
      rsp_tdata_in = rsp_tdata_ff;
      if (req_accept) begin
         rsp_tdata_in = '0;
         rsp_tdata_in[RSP_PAY_LSB +: PORT_PAY_W] =
            peek_hit ? PORT_PAY_W'(rd_any) : '0;
         rsp_tdata_in[RSP_CNT_LSB +: CNT_PORT_W] = CNT_PORT_W'(count_next);
         rsp_tdata_in[RSP_FULL_BIT]              = (count_next == DEPTH_CNT);
         rsp_tdata_in[RSP_EMPTY_BIT]             = (count_next == '0);
         rsp_tdata_in[RSP_ERR_LSB +: ERR_W]      = err;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (req_accept) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign count_in = req_accept ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* src/ple_checker.sv */
// ----------------------------------------------------------------------------
// positional list engine - port checker
// watches the request and response beats of the top level
// ----------------------------------------------------------------------------
`include "positional_list_engine_core_defines.svh"

module ple_checker
   import ple_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_W-1:0]       req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_beat;
   logic rsp_stall;
   logic req_not_peek;
   logic rsp_err_full;

   assign req_beat     = req_tvalid && req_tready;
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign req_not_peek = req_tuser != REQ_PEEK;
   assign rsp_err_full = rsp_tdata[RSP_ERR_LSB +: ERR_W] == ERR_FULL;

   // a waiting response holds still
   `PLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // every accepted request shows a response on the next cycle
   `PLE_ASSERT_NEXT(a_rsp_follows, clock, reset, req_beat,
      rsp_tvalid, "no response after request beat")

   // only a peek may return payload bits
   `PLE_ASSERT_NEXT(a_payload_zero, clock, reset, req_beat && req_not_peek,
      rsp_tdata[RSP_PAY_LSB +: PORT_PAY_W] == '0, "payload on a non-peek response")

   // a full error only ever comes with the full flag
   `PLE_ASSERT_SAME(a_full_flag, clock, reset, rsp_tvalid && rsp_err_full,
      rsp_tdata[RSP_FULL_BIT] && !rsp_tdata[RSP_EMPTY_BIT], "full error without full flag")

   // the full and empty flags never both stand
   `PLE_ASSERT_SAME(a_flags_apart, clock, reset, rsp_tvalid,
      !(rsp_tdata[RSP_FULL_BIT] && rsp_tdata[RSP_EMPTY_BIT]), "full and empty together")

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
